>>> design/qwir_pkg.sv
// ----------------------------------------------------------------------------
// qwir_pkg
// Request and status codes for the queue with indexed remove.
// ----------------------------------------------------------------------------
package qwir_pkg;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic we;
  } qwir_wctl_t;

endpackage

>>> design/qwir_ram.sv
// ----------------------------------------------------------------------------
// qwir_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qwir_ram
  import qwir_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  qwir_wctl_t            wctl,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wctl.we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/fifo_queue_with_indexed_remove.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_indexed_remove
// Bounded queue in a circular memory; indexed remove shifts later entries.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_stall, req_type, value,      | into block
//           | position                                  |
//   out     | out_valid, out_stall, status, count,      | out of block
//           | is_empty, head_value                      |
//
// Append and pop pass through the write or pointer move, the head read and
// the capture. Remove at position p with 0 < p < count-1 moves each later
// entry down by one: a memory read, then a write through the write port.
// Remove at the head or the tail, and flagged requests, skip the shift.
// Reset clears count and head pointer; memory contents are not cleared.
// A new item is taken while a result waits; a stalled result holds the block
// in the capture state until taken.
// ----------------------------------------------------------------------------
module fifo_queue_with_indexed_remove
  import qwir_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] value,
  input  logic [3:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [4:0]         count,
  output logic               is_empty,
  output logic signed [31:0] head_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_CAP  = 3'd4;

  logic [2:0]            state, state_next;
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [AW-1:0]         idx, idx_next;
  logic [1:0]            st, st_next;
  qwir_wctl_t            wctl;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [31:0]           cnt32, pos32, idx32;
  logic [63:0]           val64, head64;
  logic                  accept, load_out;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW:0] l);
    logic [AW+1:0] s;
    s = {2'b0, h} + {1'b0, l};
    if (s >= (AW+2)'(DEPTH)) begin
      s = s - (AW+2)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  qwir_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .AW(AW)) u_ram (
    .clk  (clk),
    .wctl (wctl),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cnt32    = 32'(cnt);
  assign pos32    = 32'(position);
  assign idx32    = 32'(idx);
  assign val64    = {32'b0, value};
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign load_out = (state == S_CAP) && (!out_valid || !out_stall);
  assign head64   = 64'(signed'(rdata));

  always_comb begin
    state_next = state;
    head_next  = head;
    cnt_next   = cnt;
    idx_next   = idx;
    st_next    = st;
    wctl.we    = 1'b0;
    waddr      = head;
    wdata      = val64[DATA_WIDTH-1:0];
    raddr      = head;
    case (state)
      S_IDLE: begin
        if (accept) begin
          st_next    = ST_OK;
          state_next = S_HEAD;
          case (req_type)
            REQ_APPEND: begin
              if (cnt32 >= 32'(DEPTH)) begin
                st_next = ST_FULL;
              end else begin
                wctl.we  = 1'b1;
                waddr    = phys(head, (AW+1)'(cnt));
                cnt_next = cnt + 1'b1;
              end
            end
            REQ_POP: begin
              if (cnt == '0) begin
                st_next = ST_EMPTY;
              end else begin
                head_next = phys(head, (AW+1)'(1));
                cnt_next  = cnt - 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (cnt == '0) begin
                st_next = ST_EMPTY;
              end else if (pos32 >= cnt32) begin
                st_next = ST_RANGE;
              end else if (pos32 == 0) begin
                head_next = phys(head, (AW+1)'(1));
                cnt_next  = cnt - 1'b1;
              end else if (pos32 + 1 == cnt32) begin
                cnt_next = cnt - 1'b1;
              end else begin
                idx_next   = pos32[AW-1:0];
                state_next = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        raddr      = phys(head, {1'b0, idx} + 1'b1);
        state_next = S_WR;
      end
      S_WR: begin
        wctl.we  = 1'b1;
        waddr    = phys(head, {1'b0, idx});
        wdata    = rdata;
        idx_next = idx + 1'b1;
        if (idx32 + 2 >= cnt32) begin
          cnt_next   = cnt - 1'b1;
          state_next = S_HEAD;
        end else begin
          state_next = S_RD;
        end
      end
      S_HEAD: begin
        state_next = S_CAP;
      end
      S_CAP: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    st  <= st_next;
    if (load_out) begin
      status     <= st;
      count      <= cnt32[4:0];
      is_empty   <= (cnt == '0);
      head_value <= (cnt == '0) ? 32'sd0 : signed'(head64[31:0]);
    end
  end

endmodule
